// File: rtl/etfp_pkg.sv
// Package for the escape-time fractal pixel block: widths, register codes, saturation helpers.
`default_nettype none

package etfp_pkg;

  // fixed field widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned FIELD_W = 10;
  localparam int unsigned CNT_W   = 10;
  localparam int unsigned GREY_W  = 4;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 16;

  // internal fixed point word and the shared multiplier split
  localparam int unsigned WORD_W = 48;
  localparam int unsigned EXT_W  = 50;
  localparam int unsigned MAG_W  = 47;
  localparam int unsigned HALF_W = 24;
  localparam int unsigned PROD_W = 94;

  localparam logic signed [WORD_W-1:0] MAG_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [EXT_W-1:0]  SAT_HI  = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [EXT_W-1:0]  SAT_LO  = -SAT_HI;

  // parameter defaults
  localparam int unsigned COORD_FRAC_BITS_DEF = 26;
  localparam int unsigned INDEX_BITS_DEF      = 10;
  localparam int unsigned ITER_BITS_DEF       = 10;

  localparam logic [CNT_W-1:0] MAX_ITER_RST = 10'd50;

  typedef enum logic [ADDR_W-1:0] {
    REG_ORIGIN_RE = 3'd0,
    REG_ORIGIN_IM = 3'd1,
    REG_STEP_RE   = 3'd2,
    REG_STEP_IM   = 3'd3,
    REG_MAX_ITER  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_re;
    logic signed [COORD_W-1:0] origin_im;
    logic signed [COORD_W-1:0] step_re;
    logic signed [COORD_W-1:0] step_im;
    logic        [CNT_W-1:0]   max_iter;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET_RE,
    ST_SET_IM,
    ST_CHECK,
    ST_MUL_XY,
    ST_UPDATE,
    ST_GO_XX,
    ST_MUL_XX,
    ST_MUL_YY,
    ST_FINISH
  } state_e;

  function automatic logic signed [EXT_W-1:0] ext50(input logic signed [WORD_W-1:0] v);
    ext50 = {{(EXT_W-WORD_W){v[WORD_W-1]}}, v};
  endfunction

  // symmetric saturation to +-(2^47 - 1)
  function automatic logic signed [WORD_W-1:0] sat48(input logic signed [EXT_W-1:0] v);
    if (v > SAT_HI) begin
      sat48 = MAG_MAX;
    end else if (v < SAT_LO) begin
      sat48 = -MAG_MAX;
    end else begin
      sat48 = v[WORD_W-1:0];
    end
  endfunction

  // 2x2 dither shade from count mod 4: 1, 9, 14 or 15
  function automatic logic [GREY_W-1:0] grey_cell(input logic [1:0] cnt_lsb);
    case (cnt_lsb)
      2'd0:    grey_cell = 4'd1;
      2'd1:    grey_cell = 4'd9;
      2'd2:    grey_cell = 4'd14;
      default: grey_cell = 4'd15;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: rtl/escape_time_fractal_pixel.sv
// Top level: escape-time fractal pixel with point setup, iteration sequencer and result register.
//
//  port group  dir  word layout (low bit first)
//  s_axis      in   column[9:0] row[19:10], pad to 24
//  m_axis      out  iteration_count[9:0] inside_set[10] mono_pixel[11] grey_cell[15:12]
//  cfg         in   cfg_addr_i selects register 0..4, cfg_wdata_i holds the value
//
// Per pixel: setup of both coordinates, then for each iteration a check that starts
// the product x*y on the one shared multiplier, the update, a multiplier start for x*x
// and, when x*x is done, the start of y*y; a final check, finish and idle close the
// pixel. Finish waits while the output register still holds a word.
// s_axis_tready is high only while idle; a finished word waits in the output
// register and the next pixel may be taken meanwhile.
// Reset: coordinates 0, iteration limit 50, no word pending.
`default_nettype none

module escape_time_fractal_pixel #(
  parameter int unsigned COORD_FRAC_BITS = etfp_pkg::COORD_FRAC_BITS_DEF,
  parameter int unsigned INDEX_BITS      = etfp_pkg::INDEX_BITS_DEF,
  parameter int unsigned ITER_BITS       = etfp_pkg::ITER_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [etfp_pkg::S_TDATA_W-1:0] s_axis_tdata,   // column, row
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [etfp_pkg::M_TDATA_W-1:0]      m_axis_tdata,   // count, inside, mono, grey
  input  wire logic                           cfg_we_i,
  input  wire logic [etfp_pkg::ADDR_W-1:0]    cfg_addr_i,
  input  wire logic [etfp_pkg::COORD_W-1:0]   cfg_wdata_i
);

  localparam int unsigned WW = etfp_pkg::WORD_W;
  localparam int unsigned EW = etfp_pkg::EXT_W;
  localparam int unsigned FW = etfp_pkg::FIELD_W;
  localparam int unsigned CW = etfp_pkg::CNT_W;
  localparam int unsigned LW = (ITER_BITS > CW) ? ITER_BITS : CW;
  localparam logic [LW-1:0] CMAX = LW'((64'd1 << ITER_BITS) - 64'd1);
  localparam logic [EW-1:0] ESC  = EW'(64'd1 << (COORD_FRAC_BITS + 3));

  etfp_pkg::cfg_t   cfg;
  etfp_pkg::state_e state_q, state_d;

  logic [INDEX_BITS-1:0] col_q, row_q, idx_sel;
  logic signed [etfp_pkg::COORD_W-1:0] step_sel, org_sel;
  logic signed [INDEX_BITS+32:0]       sprod;
  logic signed [WW-1:0] coord;

  logic signed [WW-1:0] cx_q, cy_q, x_q, y_q, xq_q, yq_q, pxy_q;
  logic signed [WW-1:0] x_new, y_new, mul_a, mul_b, mul_p;
  logic                 mul_start, mul_done;
  logic [ITER_BITS-1:0] it_q, it_inc, limit;
  logic [LW-1:0]        max_ext, it_ext;
  logic [EW-1:0]        mag_sum;
  logic                 cont;

  logic                 out_valid_q, out_load;
  logic [CW-1:0]        cnt_out_q;
  logic                 inside_q, mono_q, inside_d;
  logic [etfp_pkg::GREY_W-1:0] grey_q;

  etfp_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  etfp_mul #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_mul (
    .clk_i,
    .rst_ni,
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  // point setup: one small multiply per axis
  assign idx_sel  = (state_q == etfp_pkg::ST_SET_RE) ? col_q : row_q;
  assign step_sel = (state_q == etfp_pkg::ST_SET_RE) ? cfg.step_re : cfg.step_im;
  assign org_sel  = (state_q == etfp_pkg::ST_SET_RE) ? cfg.origin_re : cfg.origin_im;
  assign sprod    = $signed({1'b0, idx_sel}) * step_sel;
  assign coord    = WW'(org_sel) + WW'(sprod);

  assign max_ext = LW'(cfg.max_iter);
  assign limit   = (max_ext > CMAX) ? ITER_BITS'(CMAX) : ITER_BITS'(max_ext);
  assign it_inc  = it_q + ITER_BITS'(1);
  assign mag_sum = EW'({1'b0, xq_q}) + EW'({1'b0, yq_q});
  assign cont    = (it_inc < limit) && (mag_sum < ESC);

  assign y_new = etfp_pkg::sat48(etfp_pkg::ext50(etfp_pkg::sat48(etfp_pkg::ext50(pxy_q) <<< 1))
                                 - etfp_pkg::ext50(cy_q));
  assign x_new = etfp_pkg::sat48(etfp_pkg::ext50(etfp_pkg::sat48(etfp_pkg::ext50(xq_q)
                                 - etfp_pkg::ext50(yq_q))) - etfp_pkg::ext50(cx_q));

  assign it_ext   = LW'(it_q);
  assign inside_d = (it_q == limit);

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    mul_start     = 1'b0;
    mul_a         = x_q;
    mul_b         = y_q;
    out_load      = 1'b0;
    unique case (state_q)
      etfp_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = etfp_pkg::ST_SET_RE;
      end
      etfp_pkg::ST_SET_RE: state_d = etfp_pkg::ST_SET_IM;
      etfp_pkg::ST_SET_IM: state_d = etfp_pkg::ST_CHECK;
      etfp_pkg::ST_CHECK: begin
        if (cont) begin
          mul_start = 1'b1;
          state_d   = etfp_pkg::ST_MUL_XY;
        end else begin
          state_d = etfp_pkg::ST_FINISH;
        end
      end
      etfp_pkg::ST_MUL_XY: begin
        if (mul_done) state_d = etfp_pkg::ST_UPDATE;
      end
      etfp_pkg::ST_UPDATE: state_d = etfp_pkg::ST_GO_XX;
      etfp_pkg::ST_GO_XX: begin
        mul_start = 1'b1;
        mul_b     = x_q;
        state_d   = etfp_pkg::ST_MUL_XX;
      end
      etfp_pkg::ST_MUL_XX: begin
        mul_a = y_q;
        if (mul_done) begin
          mul_start = 1'b1;
          state_d   = etfp_pkg::ST_MUL_YY;
        end
      end
      etfp_pkg::ST_MUL_YY: begin
        if (mul_done) state_d = etfp_pkg::ST_CHECK;
      end
      etfp_pkg::ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = etfp_pkg::ST_IDLE;
        end
      end
      default: state_d = etfp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= etfp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      col_q <= INDEX_BITS'(s_axis_tdata[FW-1:0]);
      row_q <= INDEX_BITS'(s_axis_tdata[2*FW-1:FW]);
    end
    if (state_q == etfp_pkg::ST_SET_RE) cx_q <= coord;
    if (state_q == etfp_pkg::ST_SET_IM) begin
      cy_q <= coord;
      x_q  <= '0;
      y_q  <= '0;
      xq_q <= '0;
      yq_q <= '0;
      it_q <= '0;
    end
    if (state_q == etfp_pkg::ST_CHECK) it_q <= it_inc;
    if (state_q == etfp_pkg::ST_MUL_XY && mul_done) pxy_q <= mul_p;
    if (state_q == etfp_pkg::ST_UPDATE) begin
      x_q <= x_new;
      y_q <= y_new;
    end
    if (state_q == etfp_pkg::ST_MUL_XX && mul_done) xq_q <= mul_p;
    if (state_q == etfp_pkg::ST_MUL_YY && mul_done) yq_q <= mul_p;
    if (out_load) begin
      cnt_out_q <= it_ext[CW-1:0];
      inside_q  <= inside_d;
      mono_q    <= !inside_d && (it_q[1:0] != 2'd0);
      grey_q    <= inside_d ? '0 : etfp_pkg::grey_cell(it_q[1:0]);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {grey_q, mono_q, inside_q, cnt_out_q};

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a pixel is in flight");

  a_inside_not_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[10] && m_axis_tdata[11]))
    else $error("pixel marked inside and plotted");

  a_inside_no_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[15:12] == 4'd0)
    else $error("grey cell set for inside pixel");

  a_mono_from_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[10] |-> m_axis_tdata[11] == (m_axis_tdata[1:0] != 2'd0))
    else $error("mono bit disagrees with count");

endmodule

`default_nettype wire

// File: rtl/etfp_cfg.sv
// Configuration register file: coordinate origin, steps and iteration limit.
`default_nettype none

module etfp_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [etfp_pkg::ADDR_W-1:0] cfg_addr_i,
  input  wire logic [etfp_pkg::COORD_W-1:0] cfg_wdata_i,
  output etfp_pkg::cfg_t                   cfg_o
);

  etfp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (etfp_pkg::reg_idx_e'(cfg_addr_i))
        etfp_pkg::REG_ORIGIN_RE: cfg_d.origin_re = cfg_wdata_i;
        etfp_pkg::REG_ORIGIN_IM: cfg_d.origin_im = cfg_wdata_i;
        etfp_pkg::REG_STEP_RE:   cfg_d.step_re   = cfg_wdata_i;
        etfp_pkg::REG_STEP_IM:   cfg_d.step_im   = cfg_wdata_i;
        etfp_pkg::REG_MAX_ITER:  cfg_d.max_iter  = cfg_wdata_i[etfp_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_re <= '0;
      cfg_q.origin_im <= '0;
      cfg_q.step_re   <= '0;
      cfg_q.step_im   <= '0;
      cfg_q.max_iter  <= etfp_pkg::MAX_ITER_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/etfp_mul.sv
// Shared saturating fixed point multiplier: four 24x24 partial products accumulated in turn.
`default_nettype none

module etfp_mul #(
  parameter int unsigned COORD_FRAC_BITS = etfp_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [etfp_pkg::WORD_W-1:0] a_i,
  input  wire logic signed [etfp_pkg::WORD_W-1:0] b_i,
  output logic                                   done_o,
  output logic signed [etfp_pkg::WORD_W-1:0]      p_o
);

  localparam int unsigned HW = etfp_pkg::HALF_W;
  localparam int unsigned PW = etfp_pkg::PROD_W;
  localparam int unsigned MW = etfp_pkg::MAG_W;
  localparam int unsigned TOP = COORD_FRAC_BITS + MW;

  logic [MW-1:0]   mag_a_q, mag_b_q;
  logic            neg_q;
  logic [1:0]      cnt_q;
  logic            busy_q, done_q;
  logic [PW-1:0]   acc_q;

  logic signed [etfp_pkg::WORD_W-1:0] abs_a, abs_b;
  logic [HW-1:0]   op_a, op_b;
  logic [2*HW-1:0] pp;
  logic [PW-1:0]   pp_sh;
  logic            over;
  logic [MW-1:0]   mag_p;
  logic signed [etfp_pkg::WORD_W-1:0] res;

  assign abs_a = a_i[etfp_pkg::WORD_W-1] ? -a_i : a_i;
  assign abs_b = b_i[etfp_pkg::WORD_W-1] ? -b_i : b_i;

  assign op_a = cnt_q[1] ? {1'b0, mag_a_q[MW-1:HW]} : mag_a_q[HW-1:0];
  assign op_b = cnt_q[0] ? {1'b0, mag_b_q[MW-1:HW]} : mag_b_q[HW-1:0];
  assign pp   = op_a * op_b;

  always_comb begin
    case (cnt_q)
      2'd0:    pp_sh = PW'(pp);
      2'd3:    pp_sh = PW'(pp) << (2*HW);
      default: pp_sh = PW'(pp) << HW;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_a_q <= abs_a[MW-1:0];
      mag_b_q <= abs_b[MW-1:0];
      neg_q   <= a_i[etfp_pkg::WORD_W-1] ^ b_i[etfp_pkg::WORD_W-1];
      acc_q   <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
  end

  // truncate toward zero, saturate on magnitude overflow
  assign over  = |acc_q[PW-1:TOP];
  assign mag_p = acc_q[TOP-1:COORD_FRAC_BITS];
  assign res   = over ? etfp_pkg::MAG_MAX : $signed({1'b0, mag_p});
  assign p_o   = neg_q ? -res : res;
  assign done_o = done_q;

endmodule

`default_nettype wire
